/* design/lesc_pkg.sv */
// ----------------------------------------------------------------------------
// lesc_pkg
// types, register indexes and escape table for the line escape controller
// ----------------------------------------------------------------------------
`default_nettype none

package lesc_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int TIMER_W   = 16;
  localparam int ELAPSED_W = 8;
  localparam int ANGLE_W   = 9;
  localparam int RANGE_W   = 6;
  localparam int SIDE_W    = 4;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_TIME_MS   = 1'd1;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd512;
  localparam logic [TIMER_W-1:0]  EXIT_TIME_RESET = 16'd100;
  localparam logic [TIMER_W-1:0]  TIMER_MAX       = 16'hFFFF;

  localparam logic [SIDE_W-1:0] SIDE_Y_LOW  = 4'h1;
  localparam logic [SIDE_W-1:0] SIDE_X_LOW  = 4'h2;
  localparam logic [SIDE_W-1:0] SIDE_Y_HIGH = 4'h4;
  localparam logic [SIDE_W-1:0] SIDE_X_HIGH = 4'h8;
  localparam logic [SIDE_W-1:0] PAT_ALL     = 4'd15;
  localparam logic [SIDE_W-1:0] PAT_Y_PAIR  = 4'd5;
  localparam logic [SIDE_W-1:0] PAT_X_PAIR  = 4'd10;

  localparam logic [TIMER_W-1:0] FAST_LIMIT_MS = 16'd45;
  localparam logic [TIMER_W-1:0] SLOW_MARK_MS  = 16'd99;
  localparam logic [ANGLE_W-1:0] SPEED_FAST    = 9'd330;
  localparam logic [ANGLE_W-1:0] SPEED_SLOW    = 9'd230;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  inner_sample_0;
    logic [SAMPLE_W-1:0]  inner_sample_1;
    logic [SAMPLE_W-1:0]  inner_sample_2;
    logic [SAMPLE_W-1:0]  inner_sample_3;
    logic [SAMPLE_W-1:0]  outer_sample_0;
    logic [SAMPLE_W-1:0]  outer_sample_1;
    logic [SAMPLE_W-1:0]  outer_sample_2;
    logic [SAMPLE_W-1:0]  outer_sample_3;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic               recovering;
    logic [ANGLE_W-1:0] escape_direction;
    logic [ANGLE_W-1:0] escape_speed;
    logic [ANGLE_W-1:0] mask_center;
    logic [RANGE_W-1:0] mask_range;
    logic [SIDE_W-1:0]  side_pattern;
    logic               slow_flag;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [ANGLE_W-1:0] dir;
    logic [ANGLE_W-1:0] ctr;
    logic [RANGE_W-1:0] rng;
  } esc_entry_t;

  function automatic esc_entry_t esc_lookup(input logic [SIDE_W-1:0] pat);
    esc_entry_t e;
    e = '0;
    unique case (pat)
      4'd1:    e = '{1'b1, 9'd180, 9'd0,   6'd30};
      4'd2:    e = '{1'b1, 9'd270, 9'd90,  6'd60};
      4'd3:    e = '{1'b1, 9'd225, 9'd45,  6'd20};
      4'd4:    e = '{1'b1, 9'd0,   9'd180, 6'd30};
      4'd6:    e = '{1'b1, 9'd315, 9'd135, 6'd20};
      4'd7:    e = '{1'b1, 9'd270, 9'd90,  6'd60};
      4'd8:    e = '{1'b1, 9'd90,  9'd270, 6'd60};
      4'd9:    e = '{1'b1, 9'd135, 9'd315, 6'd20};
      4'd11:   e = '{1'b1, 9'd180, 9'd0,   6'd60};
      4'd12:   e = '{1'b1, 9'd45,  9'd225, 6'd20};
      4'd13:   e = '{1'b1, 9'd90,  9'd270, 6'd60};
      4'd14:   e = '{1'b1, 9'd0,   9'd180, 6'd60};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* design/lesc_threshold.sv */
// ----------------------------------------------------------------------------
// lesc_threshold
// compares the eight line samples against the threshold, one hit bit per side
// ----------------------------------------------------------------------------
`default_nettype none

module lesc_threshold
  import lesc_pkg::*;
(
  input  wire sample_t             sample,
  input  wire logic [SAMPLE_W-1:0] line_threshold,
  output logic      [SIDE_W-1:0]   hits
);

  assign hits[0] = (sample.inner_sample_0 > line_threshold) ||
                   (sample.outer_sample_0 > line_threshold);
  assign hits[1] = (sample.inner_sample_1 > line_threshold) ||
                   (sample.outer_sample_1 > line_threshold);
  assign hits[2] = (sample.inner_sample_2 > line_threshold) ||
                   (sample.outer_sample_2 > line_threshold);
  assign hits[3] = (sample.inner_sample_3 > line_threshold) ||
                   (sample.outer_sample_3 > line_threshold);

endmodule

`default_nettype wire

/* design/lesc_core.sv */
// ----------------------------------------------------------------------------
// lesc_core
// exit timer, side latches and escape table; one transaction per step
// ----------------------------------------------------------------------------
`default_nettype none

module lesc_core
  import lesc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire sample_t             sample,
  input  wire logic [SAMPLE_W-1:0] line_threshold,
  input  wire logic [TIMER_W-1:0]  exit_time_ms,
  output result_t                  result
);

  logic [TIMER_W-1:0] exit_timer, exit_timer_next;
  logic [SIDE_W-1:0]  touched_sides, touched_sides_next;
  logic [SIDE_W-1:0]  first_x_side, first_x_side_next;
  logic [SIDE_W-1:0]  first_y_side, first_y_side_next;
  logic               seek_x, seek_x_next;
  logic               seek_y, seek_y_next;
  logic [ANGLE_W-1:0] held_direction, held_direction_next;
  logic [ANGLE_W-1:0] held_mask_center, held_mask_center_next;
  logic [RANGE_W-1:0] held_mask_range, held_mask_range_next;

  logic [SIDE_W-1:0]  hits;
  logic [TIMER_W:0]   timer_sum;
  logic [TIMER_W-1:0] timer_sat;
  logic               rearm;
  logic               seek_x_on;
  logic               seek_y_on;
  logic [SIDE_W-1:0]  touched;
  logic [SIDE_W-1:0]  pattern;
  logic               recov;
  esc_entry_t         entry;

  lesc_threshold u_threshold (
    .sample         (sample),
    .line_threshold (line_threshold),
    .hits           (hits)
  );

  always_comb begin
    timer_sum = {1'b0, exit_timer} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, sample.elapsed_ms};
    timer_sat = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
    rearm     = (hits != '0) && (timer_sat > exit_time_ms);
    exit_timer_next = (hits != '0) ? '0 : timer_sat;
    touched   = touched_sides | hits;

    seek_x_on = seek_x || rearm;
    seek_y_on = seek_y || rearm;

    first_x_side_next = first_x_side;
    if (seek_x_on) begin
      if (touched[1]) begin
        first_x_side_next = SIDE_X_LOW;
      end else if (touched[3]) begin
        first_x_side_next = SIDE_X_HIGH;
      end
    end
    first_y_side_next = first_y_side;
    if (seek_y_on) begin
      if (touched[0]) begin
        first_y_side_next = SIDE_Y_LOW;
      end else if (touched[2]) begin
        first_y_side_next = SIDE_Y_HIGH;
      end
    end
    seek_x_next = seek_x_on && (first_x_side_next == '0);
    seek_y_next = seek_y_on && (first_y_side_next == '0);

    recov   = (exit_timer_next <= exit_time_ms);
    pattern = (touched == PAT_ALL) ? (first_y_side_next | first_x_side_next) : touched;
    entry   = esc_lookup(pattern);

    held_direction_next   = held_direction;
    held_mask_center_next = held_mask_center;
    held_mask_range_next  = held_mask_range;
    if (recov) begin
      if (entry.valid) begin
        held_direction_next   = entry.dir;
        held_mask_center_next = entry.ctr;
        held_mask_range_next  = entry.rng;
      end else if (pattern == PAT_Y_PAIR) begin
        if (first_x_side_next == SIDE_X_LOW) begin
          held_direction_next   = 9'd270;
          held_mask_center_next = 9'd90;
          held_mask_range_next  = 6'd30;
        end else if (first_x_side_next == SIDE_X_HIGH) begin
          held_direction_next   = 9'd90;
          held_mask_center_next = 9'd270;
          held_mask_range_next  = 6'd30;
        end
      end else if (pattern == PAT_X_PAIR) begin
        if (first_y_side_next == SIDE_Y_HIGH) begin
          held_direction_next   = 9'd0;
          held_mask_center_next = 9'd180;
          held_mask_range_next  = 6'd30;
        end else if (first_y_side_next == SIDE_Y_LOW) begin
          held_direction_next   = 9'd180;
          held_mask_center_next = 9'd0;
          held_mask_range_next  = 6'd30;
        end
      end
      touched_sides_next = pattern;
    end else begin
      touched_sides_next = '0;
      first_x_side_next  = '0;
      first_y_side_next  = '0;
    end

    result = '0;
    result.slow_flag = (exit_timer_next == SLOW_MARK_MS);
    if (recov) begin
      result.recovering       = 1'b1;
      result.escape_direction = held_direction_next;
      result.escape_speed     = (exit_timer_next < FAST_LIMIT_MS) ? SPEED_FAST : SPEED_SLOW;
      result.mask_center      = held_mask_center_next;
      result.mask_range       = held_mask_range_next;
      result.side_pattern     = pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exit_timer       <= TIMER_MAX;
      touched_sides    <= '0;
      first_x_side     <= '0;
      first_y_side     <= '0;
      seek_x           <= 1'b0;
      seek_y           <= 1'b0;
      held_direction   <= '0;
      held_mask_center <= '0;
      held_mask_range  <= '0;
    end else if (step) begin
      exit_timer       <= exit_timer_next;
      touched_sides    <= touched_sides_next;
      first_x_side     <= first_x_side_next;
      first_y_side     <= first_y_side_next;
      seek_x           <= seek_x_next;
      seek_y           <= seek_y_next;
      held_direction   <= held_direction_next;
      held_mask_center <= held_mask_center_next;
      held_mask_range  <= held_mask_range_next;
    end
  end

  a_hit_clears_timer: assert property (@(posedge clk) disable iff (rst)
    step && (hits != '0) |=> (exit_timer == '0))
    else $error("exit timer not cleared after a line hit");

  a_idle_clears_sides: assert property (@(posedge clk) disable iff (rst)
    step && !recov |=> (touched_sides == '0) && (first_x_side == '0) && (first_y_side == '0))
    else $error("side latches not cleared after recovery ended");

  a_first_x_legal: assert property (@(posedge clk) disable iff (rst)
    (first_x_side == '0) || (first_x_side == SIDE_X_LOW) || (first_x_side == SIDE_X_HIGH))
    else $error("first x side holds an illegal value");

  a_no_full_pattern: assert property (@(posedge clk) disable iff (rst)
    step && recov |-> (result.side_pattern != PAT_ALL))
    else $error("full side pattern reached the result");

endmodule

`default_nettype wire

/* design/line_escape_direction_controller.sv */
// ----------------------------------------------------------------------------
// line_escape_direction_controller
// a sample is taken into the input hold register, then stepped through the core into the result register
// throughput: one transaction per cycle while the receiver does not stall the result
// the input hold register lets one new sample enter while a result waits
// reset: synchronous rst clears the pipeline valids and escape state
// threshold and exit time registers return to 512 and 100
// ----------------------------------------------------------------------------
`default_nettype none

module line_escape_direction_controller
  import lesc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output logic                      sample_stall,
  input  wire sample_t              sample,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [SAMPLE_W-1:0] line_threshold;
  logic [TIMER_W-1:0]  exit_time_ms;
  logic                held_valid;
  sample_t             held_sample;
  logic                advance;
  result_t             core_result;

  assign advance      = held_valid && (!result_valid || !result_stall);
  assign sample_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_threshold <= THRESHOLD_RESET;
      exit_time_ms   <= EXIT_TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_THRESHOLD: line_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_EXIT_TIME_MS:   exit_time_ms   <= cfg_data[TIMER_W-1:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      held_sample <= sample;
    end
  end

  lesc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .sample         (held_sample),
    .line_threshold (line_threshold),
    .exit_time_ms   (exit_time_ms),
    .result         (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_line_escape_direction_controller.sv */
// ----------------------------------------------------------------------------
// tb_line_escape_direction_controller
// Self-checking testbench for the line escape direction controller. Sample
// transactions go in through a valid/stall channel. A cycle-free predictor
// tracks the exit timer, touched sides, first-side latches and held escape
// values. Each result transaction is compared field by field with the
// oldest prediction. Directed excursions cover the timer edges and the
// side patterns. Register extremes and random excursions with random
// sender gaps and receiver stalls follow.
// ----------------------------------------------------------------------------

module tb_line_escape_direction_controller;
  import lesc_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor state
  logic [SAMPLE_W-1:0] thr_q;
  logic [TIMER_W-1:0]  exit_limit_q;
  logic [TIMER_W-1:0]  exit_timer_q;
  logic [SIDE_W-1:0]   touched_q;
  logic [SIDE_W-1:0]   first_x_q;
  logic [SIDE_W-1:0]   first_y_q;
  logic                seek_x_q;
  logic                seek_y_q;
  logic [ANGLE_W-1:0]  held_dir_q;
  logic [ANGLE_W-1:0]  held_ctr_q;
  logic [RANGE_W-1:0]  held_rng_q;

  result_t pending_results[$];
  result_t want;
  int      fail_count = 0;
  int      sent_count = 0;
  int      checked_count = 0;
  int      setting_count = 0;
  logic    no_gaps = 1'b0;

  line_escape_direction_controller u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(8 * 400000);
    $display("Verification failed");
    $finish;
  end

  task automatic reset_escape_model();
    thr_q        = THRESHOLD_RESET;
    exit_limit_q = EXIT_TIME_RESET;
    exit_timer_q = TIMER_MAX;
    touched_q    = '0;
    first_x_q    = '0;
    first_y_q    = '0;
    seek_x_q     = 1'b0;
    seek_y_q     = 1'b0;
    held_dir_q   = '0;
    held_ctr_q   = '0;
    held_rng_q   = '0;
  endtask

  function automatic void hold_escape(input logic [ANGLE_W-1:0] d, input logic [ANGLE_W-1:0] c,
                                      input logic [RANGE_W-1:0] rg);
    held_dir_q = d;
    held_ctr_q = c;
    held_rng_q = rg;
  endfunction

  function automatic result_t predict_escape(input sample_t s);
    logic [SAMPLE_W-1:0] inner_v [4];
    logic [SAMPLE_W-1:0] outer_v [4];
    logic [TIMER_W:0]    sum;
    logic [SIDE_W-1:0]   hits;
    result_t             r;
    int                  i;
    inner_v[0] = s.inner_sample_0;
    inner_v[1] = s.inner_sample_1;
    inner_v[2] = s.inner_sample_2;
    inner_v[3] = s.inner_sample_3;
    outer_v[0] = s.outer_sample_0;
    outer_v[1] = s.outer_sample_1;
    outer_v[2] = s.outer_sample_2;
    outer_v[3] = s.outer_sample_3;
    r = '0;
    sum = {1'b0, exit_timer_q} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, s.elapsed_ms};
    exit_timer_q = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
    hits = '0;
    for (i = 0; i < 4; i++) begin
      if (inner_v[i] > thr_q || outer_v[i] > thr_q) hits[i] = 1'b1;
    end
    if (hits != '0) begin
      if (exit_timer_q > exit_limit_q) begin
        seek_x_q = 1'b1;
        seek_y_q = 1'b1;
      end
      exit_timer_q = '0;
    end
    touched_q = touched_q | hits;
    if (seek_x_q) begin
      if ((touched_q & SIDE_X_LOW) != '0) first_x_q = SIDE_X_LOW;
      else if ((touched_q & SIDE_X_HIGH) != '0) first_x_q = SIDE_X_HIGH;
      if (first_x_q != '0) seek_x_q = 1'b0;
    end
    if (seek_y_q) begin
      if ((touched_q & SIDE_Y_LOW) != '0) first_y_q = SIDE_Y_LOW;
      else if ((touched_q & SIDE_Y_HIGH) != '0) first_y_q = SIDE_Y_HIGH;
      if (first_y_q != '0) seek_y_q = 1'b0;
    end
    if (exit_timer_q <= exit_limit_q) begin
      if (touched_q == PAT_ALL) touched_q = first_y_q | first_x_q;
      case (touched_q)
        4'd1:  hold_escape(9'd180, 9'd0,   6'd30);
        4'd2:  hold_escape(9'd270, 9'd90,  6'd60);
        4'd3:  hold_escape(9'd225, 9'd45,  6'd20);
        4'd4:  hold_escape(9'd0,   9'd180, 6'd30);
        4'd6:  hold_escape(9'd315, 9'd135, 6'd20);
        4'd7:  hold_escape(9'd270, 9'd90,  6'd60);
        4'd8:  hold_escape(9'd90,  9'd270, 6'd60);
        4'd9:  hold_escape(9'd135, 9'd315, 6'd20);
        4'd11: hold_escape(9'd180, 9'd0,   6'd60);
        4'd12: hold_escape(9'd45,  9'd225, 6'd20);
        4'd13: hold_escape(9'd90,  9'd270, 6'd60);
        4'd14: hold_escape(9'd0,   9'd180, 6'd60);
        PAT_Y_PAIR: begin
          if (first_x_q == SIDE_X_LOW) hold_escape(9'd270, 9'd90, 6'd30);
          else if (first_x_q == SIDE_X_HIGH) hold_escape(9'd90, 9'd270, 6'd30);
        end
        PAT_X_PAIR: begin
          if (first_y_q == SIDE_Y_HIGH) hold_escape(9'd0, 9'd180, 6'd30);
          else if (first_y_q == SIDE_Y_LOW) hold_escape(9'd180, 9'd0, 6'd30);
        end
        default: ;
      endcase
      r.recovering       = 1'b1;
      r.escape_speed     = (exit_timer_q < FAST_LIMIT_MS) ? SPEED_FAST : SPEED_SLOW;
      r.escape_direction = held_dir_q;
      r.mask_center      = held_ctr_q;
      r.mask_range       = held_rng_q;
      r.side_pattern     = touched_q;
    end else begin
      touched_q = '0;
      first_x_q = '0;
      first_y_q = '0;
    end
    r.slow_flag = (exit_timer_q == SLOW_MARK_MS);
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] level_above();
    if (thr_q == '1) return '1;
    return SAMPLE_W'($urandom_range(1023, thr_q + 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] level_below();
    return SAMPLE_W'($urandom_range(thr_q, 0));
  endfunction

  // hit sides get one or both sensors above threshold
  function automatic sample_t make_sample(input logic [SIDE_W-1:0] sides,
                                          input logic [ELAPSED_W-1:0] el);
    logic [SAMPLE_W-1:0] inner_v [4];
    logic [SAMPLE_W-1:0] outer_v [4];
    sample_t             s;
    int                  i;
    int                  pick;
    for (i = 0; i < 4; i++) begin
      pick = $urandom_range(0, 2);
      inner_v[i] = (sides[i] && pick != 1) ? level_above() : level_below();
      outer_v[i] = (sides[i] && pick != 0) ? level_above() : level_below();
    end
    s.inner_sample_0 = inner_v[0];
    s.inner_sample_1 = inner_v[1];
    s.inner_sample_2 = inner_v[2];
    s.inner_sample_3 = inner_v[3];
    s.outer_sample_0 = outer_v[0];
    s.outer_sample_1 = outer_v[1];
    s.outer_sample_2 = outer_v[2];
    s.outer_sample_3 = outer_v[3];
    s.elapsed_ms     = el;
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    int r;
    int gap;
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall !== 1'b0);
    pending_results.push_back(predict_escape(s));
    sent_count++;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(6, 25);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINE_THRESHOLD: thr_q = data[SAMPLE_W-1:0];
      REG_EXIT_TIME_MS:   exit_limit_q = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // bits above the threshold width are junk the block must ignore
  task automatic apply_setting(input logic [SAMPLE_W-1:0] thr, input logic [TIMER_W-1:0] limit);
    wait_drained();
    write_reg(REG_LINE_THRESHOLD, {6'($urandom_range(0, 63)), thr});
    write_reg(REG_EXIT_TIME_MS, limit);
    setting_count++;
  endtask

  task automatic run_excursions(input int count);
    logic [95:0] noise;
    int          goal;
    int          kind;
    goal = sent_count + count;
    while (sent_count < goal) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        noise = {$urandom, $urandom, $urandom};
        send_sample(noise[$bits(sample_t)-1:0]);
      end else if (kind == 9) begin
        repeat ($urandom_range(1, 4)) send_sample(make_sample('0, 8'($urandom_range(128, 255))));
      end else if (kind == 8) begin
        repeat ($urandom_range(3, 10)) send_sample(make_sample('0, 8'($urandom_range(0, 12))));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_sample(make_sample(4'($urandom_range(1, 15)), 8'($urandom_range(0, 30))));
          if ($urandom_range(0, 2) == 0)
            send_sample(make_sample('0, 8'($urandom_range(0, 40))));
        end
        repeat ($urandom_range(0, 4)) send_sample(make_sample('0, 8'($urandom_range(0, 60))));
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_directed_cases();
    sample_t s;
    send_sample(make_sample('0, 8'd0));
    s = '0;
    s.elapsed_ms = '1;
    send_sample(s);
    // every side at full scale, resolved through the first sides
    s = '1;
    send_sample(s);
    // walk the timer across the speed change, the slow mark and the limit
    s = '0;
    s.elapsed_ms = 8'd44;
    send_sample(s);
    s.elapsed_ms = 8'd1;
    send_sample(s);
    s.elapsed_ms = 8'd54;
    send_sample(s);
    s.elapsed_ms = 8'd1;
    send_sample(s);
    send_sample(s);
    s = '0;
    s.inner_sample_0 = THRESHOLD_RESET;
    send_sample(s);
    s = '0;
    s.outer_sample_0 = SAMPLE_W'(THRESHOLD_RESET + 1);
    send_sample(s);
    // y pair with no x side keeps the held values
    s = '0;
    s.inner_sample_2 = '1;
    send_sample(s);
    s = '0;
    s.elapsed_ms = '1;
    send_sample(s);
    // x pair with no y side
    s = '0;
    s.outer_sample_1 = '1;
    s.inner_sample_3 = '1;
    send_sample(s);
    s = '0;
    s.outer_sample_0 = '1;
    send_sample(s);
    s = '0;
    s.elapsed_ms = '1;
    send_sample(s);
    send_sample(make_sample(SIDE_X_HIGH, 8'd3));
    send_sample(make_sample(SIDE_Y_LOW, 8'd3));
    send_sample(make_sample(SIDE_X_LOW | SIDE_Y_HIGH, 8'd3));
    send_sample(s);
  endtask

  task automatic test_register_extremes();
    apply_setting(10'd0, 16'd0);
    run_excursions(35);
    apply_setting(10'd1023, 16'd65535);
    run_excursions(30);
    apply_setting(10'd0, 16'd65535);
    run_excursions(35);
    apply_setting(10'd1023, 16'd0);
    run_excursions(20);
    apply_setting(10'd1, 16'd1);
    run_excursions(35);
  endtask

  task automatic test_random_excursions();
    int ph;
    apply_setting(THRESHOLD_RESET, EXIT_TIME_RESET);
    run_excursions(150);
    for (ph = 0; ph < 3; ph++) begin
      apply_setting(10'($urandom_range(100, 900)), 16'($urandom_range(30, 300)));
      run_excursions(70);
      // hold off until every pending result has come back
      wait_drained();
      run_excursions(70);
    end
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result transaction, nothing pending", $time);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        compare_field("recovering", want.recovering, result.recovering);
        compare_field("escape_direction", want.escape_direction, result.escape_direction);
        compare_field("escape_speed", want.escape_speed, result.escape_speed);
        compare_field("mask_center", want.mask_center, result.mask_center);
        compare_field("mask_range", want.mask_range, result.mask_range);
        compare_field("side_pattern", want.side_pattern, result.side_pattern);
        compare_field("slow_flag", want.slow_flag, result.slow_flag);
      end
    end
  end

  // receiver: short stalls, a few long ones, and free-running stretches
  initial begin
    int r;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(10, 50)) @(posedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat ((r < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30)) @(posedge clk);
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    reset_escape_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_register_extremes();
    test_random_excursions();
    wait_drained();
    $display("sent %0d sample transactions, checked %0d results", sent_count, checked_count);
    $display("register settings applied: %0d, including threshold and exit time extremes",
             setting_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
